// ===== design/lfd_pkg.sv =====
`default_nettype none
package lfd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned EVENT_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned SEQ_SHIFT = 6;
    localparam int unsigned M_DATA_W  = 16;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_FLAG    = 3'd1,
        PH_ADDR    = 3'd2,
        PH_CTRL    = 3'd3,
        PH_HDRPEND = 3'd4,
        PH_BODY    = 3'd5
    } phase_t;

    localparam logic [EVENT_W-1:0] EV_PAYLOAD = 2'd0;
    localparam logic [EVENT_W-1:0] EV_COMMAND = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DATA_OK = 2'd2;
    localparam logic [EVENT_W-1:0] EV_REJECT  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAG    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STUFF   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_value;
        logic [BYTE_W-1:0] escape_value;
        logic [BYTE_W-1:0] stuff_mask;
        logic [BYTE_W-1:0] address_value;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic              escape_pending;
        logic [BYTE_W-1:0] addr_seen;
        logic [BYTE_W-1:0] ctrl_seen;
        logic              header_ok;
        logic [BYTE_W-1:0] held_byte;
        logic              held_valid;
        logic [BYTE_W-1:0] running_xor;
    } state_t;

    typedef struct packed {
        logic               reply_seq;
        logic [BYTE_W-1:0]  value;
        logic [EVENT_W-1:0] event_res;
    } result_t;

endpackage
`default_nettype wire

// ===== design/link_frame_deframer.sv =====
`default_nettype none
// Channel   Direction  Fields (low bit first)
// s_axis    in         tdata: line_byte[7:0]
// m_axis    out        tuser: event_res[1:0]; tdata: value[7:0], reply_seq[8], zeros[15:9]
// cfg       in         write enable, register index, 8-bit data
//
// One line byte can be taken every clock cycle unless a result waits on m_tready.
// An accepted byte is stepped once the result slot is free, and its result is offered
// from there (input register, then result register).
// aresetn is synchronous and active low; it restores the register defaults and
// puts the receiver back to hunting for an opening flag.
// While a result waits on m_tready, the byte in the input register is held even
// if it would produce nothing, and a full input register drops s_tready.
module link_frame_deframer (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,    // line_byte[7:0]
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [1:0] m_tuser,    // event_res[1:0]
    output logic [15:0] m_tdata,   // value[7:0], reply_seq[8]
    input  wire        cfg_wr_en,
    input  wire [1:0]  cfg_addr,
    input  wire [7:0]  cfg_wr_data
);
    import lfd_pkg::*;

    cfg_t              cfg_reg;
    state_t            state_reg;
    state_t            state_next;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic              out_free;
    logic              step_en;
    logic              step_emit;
    result_t           step_res;

    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    lfd_step u_step (
        .cfg       (cfg_reg),
        .cur       (state_reg),
        .line_byte (in_byte_reg),
        .nxt       (state_next),
        .emit      (step_emit),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_value    <= 8'd126;
            cfg_reg.escape_value  <= 8'd125;
            cfg_reg.stuff_mask    <= 8'd32;
            cfg_reg.address_value <= 8'd3;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FLAG:    cfg_reg.flag_value    <= cfg_wr_data;
                CFG_ESCAPE:  cfg_reg.escape_value  <= cfg_wr_data;
                CFG_STUFF:   cfg_reg.stuff_mask    <= cfg_wr_data;
                CFG_ADDRESS: cfg_reg.address_value <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // All-zero state is hunting with every field cleared.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= step_emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (step_en && step_emit) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.event_res;
    assign m_tdata  = {{(M_DATA_W - BYTE_W - 1){1'b0}}, out_res_reg.reply_seq,
                       out_res_reg.value};

endmodule
`default_nettype wire

// ===== design/lfd_step.sv =====
`default_nettype none
module lfd_step (
    input  wire lfd_pkg::cfg_t    cfg,
    input  wire lfd_pkg::state_t  cur,
    input  wire [7:0]             line_byte,
    output lfd_pkg::state_t       nxt,
    output logic                  emit,
    output lfd_pkg::result_t      res
);
    import lfd_pkg::*;

    logic [BYTE_W-1:0] body_d;
    logic              body_take;

    always_comb begin
        nxt       = cur;
        emit      = 1'b0;
        res       = '0;
        body_d    = line_byte;
        body_take = 1'b0;

        unique case (cur.phase)
            PH_FLAG: begin
                if (line_byte == cfg.address_value) begin
                    nxt.addr_seen      = line_byte;
                    nxt.escape_pending = 1'b0;
                    nxt.header_ok      = 1'b0;
                    nxt.held_valid     = 1'b0;
                    nxt.held_byte      = '0;
                    nxt.running_xor    = '0;
                    nxt.phase          = PH_ADDR;
                end else if (line_byte != cfg.flag_value) begin
                    nxt.phase = PH_HUNT;
                end
            end
            PH_ADDR: begin
                if (line_byte == cfg.flag_value) begin
                    nxt.phase = PH_FLAG;
                end else begin
                    nxt.ctrl_seen = line_byte;
                    nxt.phase     = PH_CTRL;
                end
            end
            PH_CTRL, PH_HDRPEND, PH_BODY: begin
                if (line_byte == cfg.flag_value) begin
                    if (cur.phase == PH_CTRL) begin
                        nxt.phase = PH_FLAG;
                    end else begin
                        // Closing flag: classify the frame from what was gathered.
                        emit          = 1'b1;
                        res.value     = cur.ctrl_seen;
                        res.reply_seq = (cur.ctrl_seen[BYTE_W-1:SEQ_SHIFT] == '0);
                        if (cur.escape_pending || cur.phase != PH_BODY) begin
                            res.event_res = EV_REJECT;
                        end else if (!cur.held_valid) begin
                            res.event_res = cur.header_ok ? EV_COMMAND : EV_REJECT;
                        end else begin
                            res.event_res = (cur.header_ok && cur.running_xor == cur.held_byte)
                                            ? EV_DATA_OK : EV_REJECT;
                        end
                        nxt.escape_pending = 1'b0;
                        nxt.phase          = PH_HUNT;
                    end
                end else if (cur.escape_pending) begin
                    nxt.escape_pending = 1'b0;
                    body_d             = line_byte ^ cfg.stuff_mask;
                    body_take          = 1'b1;
                end else if (line_byte == cfg.escape_value) begin
                    nxt.escape_pending = 1'b1;
                    if (cur.phase == PH_CTRL) begin
                        nxt.phase = PH_HDRPEND;
                    end
                end else begin
                    body_take = 1'b1;
                end

                if (body_take) begin
                    if (cur.phase != PH_BODY) begin
                        // The first body byte is the header check.
                        nxt.header_ok = (body_d == (cur.addr_seen ^ cur.ctrl_seen));
                        nxt.phase     = PH_BODY;
                    end else begin
                        // Payload leaves one byte late, so the last one stays as the check.
                        if (cur.held_valid) begin
                            emit            = 1'b1;
                            res.event_res   = EV_PAYLOAD;
                            res.value       = cur.held_byte;
                            nxt.running_xor = cur.running_xor ^ cur.held_byte;
                        end
                        nxt.held_byte  = body_d;
                        nxt.held_valid = 1'b1;
                    end
                end
            end
            default: begin
                nxt.phase = (line_byte == cfg.flag_value) ? PH_FLAG : PH_HUNT;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== verif/lfd_frame_checker.sv =====
module lfd_frame_checker (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_tvalid,
    input  wire                         s_tready,
    input  wire [7:0]                   s_tdata,
    input  wire                         m_tvalid,
    input  wire                         m_tready,
    input  wire [1:0]                   m_tuser,
    input  wire [lfd_pkg::M_DATA_W-1:0] m_tdata,
    input  wire                         cfg_wr_en,
    input  wire [1:0]                   cfg_addr,
    input  wire [7:0]                   cfg_wr_data,
    output int unsigned                 errors,
    output int unsigned                 pending
);
    import lfd_pkg::*;

    localparam logic [BYTE_W-1:0] FLAG_AT_RESET    = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_AT_RESET  = 8'h7D;
    localparam logic [BYTE_W-1:0] STUFF_AT_RESET   = 8'h20;
    localparam logic [BYTE_W-1:0] ADDRESS_AT_RESET = 8'h03;

    cfg_t              regs;
    phase_t            phase_now;
    logic              escaped;
    logic [BYTE_W-1:0] addr_byte;
    logic [BYTE_W-1:0] ctrl_byte;
    logic              header_good;
    logic [BYTE_W-1:0] held;
    logic              held_full;
    logic [BYTE_W-1:0] payload_xor;

    result_t expected_events[$];

    function automatic result_t make_event(input logic [EVENT_W-1:0] ev,
                                           input logic [BYTE_W-1:0] val,
                                           input logic seq);
        result_t r;
        r.event_res = ev;
        r.value     = val;
        r.reply_seq = seq;
        return r;
    endfunction

    // The first destuffed body byte is the header check; later ones are held
    // back by one so that the final byte can be taken as the payload check.
    task automatic take_body_byte(input logic [BYTE_W-1:0] d);
        if (phase_now != PH_BODY) begin
            header_good = (d == (addr_byte ^ ctrl_byte));
            phase_now   = PH_BODY;
        end else begin
            if (held_full) begin
                expected_events.push_back(make_event(EV_PAYLOAD, held, 1'b0));
                payload_xor = payload_xor ^ held;
            end
            held      = d;
            held_full = 1'b1;
        end
    endtask

    task automatic close_frame();
        logic [EVENT_W-1:0] ev;
        logic               seq;
        seq = (ctrl_byte[7:SEQ_SHIFT] == '0);
        if (escaped || phase_now != PH_BODY)
            ev = EV_REJECT;
        else if (!held_full)
            ev = header_good ? EV_COMMAND : EV_REJECT;
        else
            ev = (header_good && payload_xor == held) ? EV_DATA_OK : EV_REJECT;
        expected_events.push_back(make_event(ev, ctrl_byte, seq));
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        case (phase_now)
            PH_FLAG: begin
                // The address test comes first, so an address equal to the
                // flag is still taken as the address.
                if (b == regs.address_value) begin
                    addr_byte   = b;
                    escaped     = 1'b0;
                    header_good = 1'b0;
                    held_full   = 1'b0;
                    held        = '0;
                    payload_xor = '0;
                    phase_now   = PH_ADDR;
                end else if (b != regs.flag_value) begin
                    phase_now = PH_HUNT;
                end
            end
            PH_ADDR: begin
                if (b == regs.flag_value) begin
                    phase_now = PH_FLAG;
                end else begin
                    ctrl_byte = b;
                    phase_now = PH_CTRL;
                end
            end
            PH_CTRL, PH_HDRPEND, PH_BODY: begin
                // A flag always ends the body, even straight after an escape.
                if (b == regs.flag_value) begin
                    if (phase_now == PH_CTRL) begin
                        phase_now = PH_FLAG;
                    end else begin
                        close_frame();
                        escaped   = 1'b0;
                        phase_now = PH_HUNT;
                    end
                end else if (escaped) begin
                    escaped = 1'b0;
                    take_body_byte(b ^ regs.stuff_mask);
                end else if (b == regs.escape_value) begin
                    escaped = 1'b1;
                    if (phase_now == PH_CTRL)
                        phase_now = PH_HDRPEND;
                end else begin
                    take_body_byte(b);
                end
            end
            default: begin
                if (b == regs.flag_value)
                    phase_now = PH_FLAG;
                else
                    phase_now = PH_HUNT;
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input result_t want,
                                 input logic [EVENT_W-1:0] got_kind,
                                 input logic [M_DATA_W-1:0] got);
        errors++;
        if (errors <= 10)
            $display("%s: want ev %0d val %02h seq %0d, got ev %0d val %02h seq %0d",
                     what, want.event_res, want.value, want.reply_seq,
                     got_kind, got[7:0], got[8]);
    endtask

    always @(posedge aclk) begin
        result_t                want;
        logic [M_DATA_W-1:0]    want_word;
        if (!aresetn) begin
            regs.flag_value    = FLAG_AT_RESET;
            regs.escape_value  = ESCAPE_AT_RESET;
            regs.stuff_mask    = STUFF_AT_RESET;
            regs.address_value = ADDRESS_AT_RESET;
            phase_now   = PH_HUNT;
            escaped     = 1'b0;
            addr_byte   = '0;
            ctrl_byte   = '0;
            header_good = 1'b0;
            held        = '0;
            held_full   = 1'b0;
            payload_xor = '0;
            expected_events.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_FLAG:    regs.flag_value    = cfg_wr_data;
                    CFG_ESCAPE:  regs.escape_value  = cfg_wr_data;
                    CFG_STUFF:   regs.stuff_mask    = cfg_wr_data;
                    CFG_ADDRESS: regs.address_value = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    note_mismatch("result with nothing expected", '0, m_tuser, m_tdata);
                end else begin
                    want      = expected_events.pop_front();
                    want_word = '0;
                    want_word[BYTE_W-1:0] = want.value;
                    want_word[BYTE_W]     = want.reply_seq;
                    if (m_tuser !== want.event_res || m_tdata !== want_word)
                        note_mismatch("result mismatch", want, m_tuser, m_tdata);
                end
            end
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
        end
        pending = expected_events.size();
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import lfd_pkg::*;

    localparam int RANDOM_ITEMS = 770;
    localparam int SEGMENT_ITEMS = 110;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [1:0]          m_tuser;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_wr_en;
    logic [1:0]          cfg_addr;
    logic [7:0]          cfg_wr_data;

    int unsigned mismatches;
    int unsigned outstanding;

    // Settings as last written, used to build well-formed frames.
    logic [7:0] cur_flag;
    logic [7:0] cur_esc;
    logic [7:0] cur_mask;
    logic [7:0] cur_addr;

    bit steady;
    int sent;
    logic [7:0] warmup_bytes [0:23];

    link_frame_deframer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    lfd_frame_checker frame_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .errors      (mismatches),
        .pending     (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("FAIL link_frame_deframer");
        $finish;
    end

    // Result side: a random stall before each transaction unless in a steady stretch.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            @(negedge aclk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        @(negedge aclk);
        sent++;
    endtask

    task automatic send_body(input logic [7:0] b);
        if (b == cur_flag || b == cur_esc) begin
            send_byte(cur_esc);
            send_byte(b ^ cur_mask);
        end else begin
            send_byte(b);
        end
    endtask

    task automatic send_frame();
        logic [7:0] ctrl;
        logic [7:0] hdr;
        logic [7:0] chk;
        logic [7:0] pb;
        int         n;
        bit         command;
        command = ($urandom_range(0, 3) == 0);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
        ctrl = 8'($urandom);
        if (ctrl == cur_flag)
            ctrl = ~ctrl;
        hdr = cur_addr ^ ctrl;
        if ($urandom_range(0, 7) == 0)
            hdr = hdr ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 3) == 0)
            send_byte(cur_flag);
        send_byte(cur_flag);
        send_byte(cur_addr);
        send_byte(ctrl);
        send_body(hdr);
        if (!command) begin
            chk = '0;
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0:       pb = cur_flag;
                    1:       pb = cur_esc;
                    default: pb = 8'($urandom);
                endcase
                chk = chk ^ pb;
                send_body(pb);
            end
            if ($urandom_range(0, 7) == 0)
                chk = chk ^ 8'($urandom_range(1, 255));
            send_body(chk);
        end
        // Occasionally leave an escape dangling in front of the closing flag.
        if ($urandom_range(0, 15) == 0)
            send_byte(cur_esc);
        send_byte(cur_flag);
    endtask

    task automatic send_broken();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: begin
                b = 8'($urandom);
                if (b == cur_addr)
                    b = ~b;
                send_byte(cur_flag);
                send_byte(b);
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
            end
            1: begin
                // A flag inside the header restarts the frame that follows.
                send_byte(cur_flag);
                send_byte(cur_addr);
                if ($urandom_range(0, 1) == 0) begin
                    b = 8'($urandom);
                    if (b == cur_flag)
                        b = ~b;
                    send_byte(b);
                end
                send_frame();
            end
            2: begin
                send_byte(cur_flag);
                send_byte(cur_addr);
                send_byte(8'($urandom));
                repeat ($urandom_range(0, 4)) send_body(8'($urandom));
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end
            default: begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 3) == 0)
                        send_byte(cur_flag);
                    else
                        send_byte(8'($urandom));
                end
            end
        endcase
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait for the block to drain; bytes that cause no result still need the pipeline.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        int next_cfg_at;
        int segment;
        int limit;
        int pick;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        aresetn     = 1'b0;
        steady      = 1'b0;
        sent        = 0;
        cur_flag    = 8'h7E;
        cur_esc     = 8'h7D;
        cur_mask    = 8'h20;
        cur_addr    = 8'h03;
        // Repeated flags and a good command frame; a data frame with stuffed payload
        // and check; a flag inside the header followed by a dangling escape; noise.
        warmup_bytes = '{8'h7E, 8'h7E, 8'h03, 8'h00, 8'h03, 8'h7E,
                         8'h7E, 8'h03, 8'h40, 8'h43, 8'h7D, 8'h5E, 8'h7D, 8'h5E, 8'h7E,
                         8'h7E, 8'h03, 8'h7E, 8'h03, 8'hFF, 8'h7D, 8'h7E,
                         8'h00, 8'hFF};

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (warmup_bytes[i])
            send_byte(warmup_bytes[i]);

        next_cfg_at = sent;
        segment     = 0;
        limit       = sent + RANDOM_ITEMS;
        while (sent < limit) begin
            if (sent >= next_cfg_at) begin
                settle();
                case (segment)
                    0: begin
                        cur_flag = 8'h00; cur_esc = 8'hFF;
                        cur_mask = 8'hFF; cur_addr = 8'h00;
                    end
                    1: begin
                        // Address equal to the flag.
                        cur_flag = 8'hFF; cur_esc = 8'h00;
                        cur_mask = 8'h80; cur_addr = 8'hFF;
                    end
                    2: begin
                        // Escape equal to the flag, so it never acts as an escape.
                        cur_flag = 8'h55; cur_esc = 8'h55;
                        cur_mask = 8'h01; cur_addr = 8'hAA;
                    end
                    3: begin
                        cur_flag = 8'h7E; cur_esc = 8'h7D;
                        cur_mask = 8'h00; cur_addr = 8'h03;
                    end
                    4: begin
                        cur_flag = 8'h7E; cur_esc = 8'h7D;
                        cur_mask = 8'h20; cur_addr = 8'h03;
                    end
                    default: begin
                        cur_flag = 8'($urandom); cur_esc = 8'($urandom);
                        cur_mask = 8'($urandom); cur_addr = 8'($urandom);
                    end
                endcase
                write_reg(CFG_FLAG, cur_flag);
                write_reg(CFG_ESCAPE, cur_esc);
                write_reg(CFG_STUFF, cur_mask);
                write_reg(CFG_ADDRESS, cur_addr);
                segment++;
                next_cfg_at = sent + SEGMENT_ITEMS;
            end
            steady = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 78)
                send_frame();
            else
                send_broken();
        end

        steady = 1'b0;
        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("PASS link_frame_deframer");
        else
            $display("FAIL link_frame_deframer");
        $finish;
    end

endmodule
